// ----- hdl/b64dec_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64dec_pkg
// Types, character codes and the alphabet lookup for the base64 decoder core.
// ---------------------------------------------------------------------------
package b64dec_pkg;

  // character codes
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

  // alphabet offsets
  localparam logic [5:0] DIGIT_LC_BASE  = 6'd26;
  localparam logic [5:0] DIGIT_NUM_BASE = 6'd52;
  localparam logic [5:0] DIGIT_PLUS     = 6'd62;
  localparam logic [5:0] DIGIT_SLASH    = 6'd63;

  // accumulator geometry
  localparam int unsigned ACC_W     = 12;
  localparam int unsigned PEND_W    = 4;
  localparam logic [4:0]  PEND_MAX  = 5'd12;
  localparam logic [4:0]  BYTE_BITS = 5'd8;
  localparam logic [4:0]  DIGIT_BITS = 5'd6;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       payload_done;
    logic       decoded_nonempty;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } digit_t;

  // map one character through the standard alphabet
  function automatic digit_t b64_digit(input logic [7:0] c);
    digit_t d;
    d.hit   = 1'b1;
    d.value = 6'd0;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      d.value = 6'(c - CHAR_UC_A);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      d.value = 6'(c - CHAR_LC_A) + DIGIT_LC_BASE;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.value = 6'(c - CHAR_ZERO) + DIGIT_NUM_BASE;
    end else if (c == CHAR_PLUS) begin
      d.value = DIGIT_PLUS;
    end else if (c == CHAR_SLASH) begin
      d.value = DIGIT_SLASH;
    end else begin
      d.hit = 1'b0;
    end
    return d;
  endfunction

endpackage

// ----- hdl/tolerant_base64_decoder_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tolerant_base64_decoder_core
// Decodes a base64 character stream, one character per transaction, skipping
// characters outside the alphabet and stopping at the first pad character.
// ---------------------------------------------------------------------------
//   channel  direction  payload     handshake
//   in       input      in_item_t   in_valid / in_stall
//   out      output     out_item_t  out_valid / out_stall
//
// One character is taken per cycle while in_stall is low; decode state updates
// at the accepting edge and the result is registered (into skid if out is held).
// A result waits in the output register; a second one parks in a skid
// register, and in_stall is simply that skid register being full.
// rst is synchronous and clears all decode state and empties both result stages.
// Characters that yield no byte and are not last produce no out transaction.
// ---------------------------------------------------------------------------
module tolerant_base64_decoder_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  b64dec_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output b64dec_pkg::out_item_t out_data
);
  import b64dec_pkg::*;

  logic [ACC_W-1:0]  bit_accumulator;
  logic [PEND_W-1:0] pending_bits;
  logic              padding_seen;
  logic              any_byte_out;

  logic [ACC_W-1:0]  bit_accumulator_next;
  logic [PEND_W-1:0] pending_bits_next;
  logic              padding_seen_next;
  logic              any_byte_out_next;

  out_item_t res;
  logic      res_present;
  out_item_t skid_data;
  logic      skid_valid;

  digit_t     digit;
  logic [4:0] pend_sum;
  logic [4:0] pend_clamp;
  logic [7:0] byte_sel;
  logic       in_fire;
  logic       out_take;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // one character step
  always_comb begin
    digit                = b64_digit(in_data.char_in);
    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    padding_seen_next    = padding_seen;
    any_byte_out_next    = any_byte_out;
    pend_sum             = {1'b0, pending_bits} + DIGIT_BITS;
    pend_clamp           = (pend_sum > PEND_MAX) ? PEND_MAX : pend_sum;
    byte_sel             = 8'd0;
    res                  = '0;
    if (!padding_seen) begin
      if (in_data.char_in == CHAR_PAD) begin
        padding_seen_next = 1'b1;
      end else if (digit.hit) begin
        bit_accumulator_next = {bit_accumulator[ACC_W-7:0], digit.value};
        if (pend_clamp >= BYTE_BITS) begin
          pending_bits_next = PEND_W'(pend_clamp - BYTE_BITS);
          byte_sel = 8'(bit_accumulator_next >> pending_bits_next);
          res.byte_out   = byte_sel;
          res.byte_valid = 1'b1;
          any_byte_out_next = 1'b1;
        end else begin
          pending_bits_next = PEND_W'(pend_clamp);
        end
      end
    end
    res.payload_done     = in_data.last_char;
    res.decoded_nonempty = in_data.last_char && any_byte_out_next;
    res_present          = res.byte_valid || in_data.last_char;
  end

  // decode state, back to reset after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      pending_bits    <= '0;
      padding_seen    <= 1'b0;
      any_byte_out    <= 1'b0;
    end else if (in_fire) begin
      if (in_data.last_char) begin
        bit_accumulator <= '0;
        pending_bits    <= '0;
        padding_seen    <= 1'b0;
        any_byte_out    <= 1'b0;
      end else begin
        bit_accumulator <= bit_accumulator_next;
        pending_bits    <= pending_bits_next;
        padding_seen    <= padding_seen_next;
        any_byte_out    <= any_byte_out_next;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_present;
      end
    end else if (in_fire && res_present) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (in_fire && res_present) begin
      skid_data <= res;
    end
  end

  // pending bit count stays even and within the accumulator
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pending_bits <= PEND_W'(PEND_MAX) && !pending_bits[0])
    else $error("pending bit count out of range");

  // skid register is only used behind a held output
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full while output empty");

  // the last character returns the decoder to its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.last_char) |=>
      (pending_bits == '0 && !padding_seen && !any_byte_out))
    else $error("state not cleared after last character");

  // a nonempty flag comes only with the done flag, and no byte without valid
  a_out_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!out_data.decoded_nonempty || out_data.payload_done) &&
                   (out_data.byte_valid || out_data.byte_out == 8'd0)))
    else $error("inconsistent result flags");

  // characters after the pad emit no byte
  a_pad_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && padding_seen) |-> !res.byte_valid)
    else $error("byte emitted after padding");

endmodule
